[hdl/aht_pkg.sv]
// ----------------------------------------------------------------------------
// aht_pkg
// Shared types, constants and helpers for the address hit profile table.
// ----------------------------------------------------------------------------
package aht_pkg;

   // table size default
   localparam int TABLE_ENTRIES_DEF = 64;

   // field widths and saturation limits
   localparam int ADDR_W   = 64;
   localparam int HITS_W   = 32;
   localparam int RUN_W    = 7;
   localparam int WEIGHT_W = 38;
   localparam int INSN_W   = 48;
   localparam int IDX_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [HITS_W-1:0] HIT_MAX  = '1;
   localparam logic [INSN_W-1:0] INSN_MAX = '1;
   localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_STRIDE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_WINDOW     = 2'd2;

   // register reset values
   localparam logic                  SORT_ENABLE_RST    = 1'b1;
   localparam logic [CSR_DATA_W-1:0] ADDRESS_STRIDE_RST = 8'd4;
   localparam logic [CSR_DATA_W-1:0] HIT_WINDOW_RST     = 8'd4;

   // request codes
   localparam logic REQ_LOG  = 1'b0;
   localparam logic REQ_DUMP = 1'b1;

   // response kinds
   localparam logic KIND_LOG  = 1'b0;
   localparam logic KIND_DUMP = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] address;
   } aht_req_type;

   typedef struct packed {
      logic                kind;
      logic [IDX_W-1:0]    entry_index;
      logic [ADDR_W-1:0]   entry_address;
      logic [RUN_W-1:0]    run_length;
      logic [HITS_W-1:0]   hit_total;
      logic [WEIGHT_W-1:0] weighted_count;
      logic [INSN_W-1:0]   instruction_total;
      logic                newly_added;
      logic                dropped_full;
      logic                entry_present;
      logic                last;
   } aht_rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [HITS_W-1:0] hits;
      logic [RUN_W-1:0]  run;
   } aht_tab_entry_type;

   // one coalesced entry waiting to be ranked
   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [HITS_W-1:0]   hits;
      logic [RUN_W-1:0]    run;
      logic [WEIGHT_W-1:0] weight;
   } aht_work_entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LSCAN,
      S_LFIN,
      S_DSCAN,
      S_SSCAN,
      S_SMERGE,
      S_RSCAN,
      S_REMIT
   } aht_state_type;

   // run length times hits, ranking key
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [RUN_W-1:0] run,
                                                     input logic [HITS_W-1:0] hits);
      logic [RUN_W+HITS_W-1:0] prod;
      prod = {{HITS_W{1'b0}}, run} * {{RUN_W{1'b0}}, hits};
      return prod[WEIGHT_W-1:0];
   endfunction

   // x ranks before y: larger weight first, then lower address
   function automatic logic ranks_before(input logic [WEIGHT_W-1:0] wx,
                                         input logic [ADDR_W-1:0]   ax,
                                         input logic [WEIGHT_W-1:0] wy,
                                         input logic [ADDR_W-1:0]   ay);
      logic res;
      if (wx != wy) begin
         res = (wx > wy);
      end else begin
         res = (ax < ay);
      end
      return res;
   endfunction

endpackage

[hdl/aht_ram.sv]
// ----------------------------------------------------------------------------
// aht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module aht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/address_hit_profile_table.sv]
// ----------------------------------------------------------------------------
// address_hit_profile_table
// Instruction address profiler: hit counting table with an optionally sorted, coalesced dump.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every result appears
// for one cycle with rsp_valid and cannot be held off, so the receiver must
// take it then. Entries live in one table RAM with a single read port, and
// each request walks that RAM one entry per cycle. A log request makes a full
// scan of the n entries in use, then a write-back and acknowledge state.
// A dump with sorting off gives one result per cycle. With sorting on,
// ordering by address takes n + 1 scans, and ranking the m coalesced entries
// takes m scans over a second RAM, one result after each scan. A dump of an
// empty table answers on the cycle after it is taken. Configuration must be
// written only while busy is low by the user; the block does not enforce it.
// ----------------------------------------------------------------------------
module address_hit_profile_table
   import aht_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  aht_req_type           req_payload,
   output logic                  rsp_valid,
   output aht_rsp_type           rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // control state
   aht_state_type state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [INSN_W-1:0]     insn_ff, insn_in;
   logic                  sort_en_ff;
   logic [CSR_DATA_W-1:0] stride_ff;
   logic [CSR_DATA_W-1:0] window_ff;

   // scan engine
   logic [CW-1:0] scan_j_ff, scan_j_in;
   logic          scan_v_ff, scan_v_in;
   logic [IW-1:0] scan_k_ff, scan_k_in;
   logic [CW-1:0] scan_limit;
   logic          scanning, scan_issue, data_last, scan_done;

   // per request datapath
   logic [ADDR_W-1:0]   req_addr_ff, req_addr_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic [ADDR_W-1:0]   best_addr_ff, best_addr_in;
   logic [HITS_W-1:0]   best_hits_ff, best_hits_in;
   logic [RUN_W-1:0]    best_run_ff, best_run_in;
   logic [WEIGHT_W-1:0] best_w_ff, best_w_in;
   logic [ADDR_W-1:0]   lower_ff, lower_in;
   logic                have_lower_ff, have_lower_in;
   logic [ADDR_W-1:0]   head_addr_ff, head_addr_in;
   logic [HITS_W-1:0]   head_hits_ff, head_hits_in;
   logic [RUN_W-1:0]    head_run_ff, head_run_in;
   logic [ADDR_W-1:0]   prev_ff, prev_in;
   logic                have_head_ff, have_head_in;
   logic [CW-1:0]       m_ff, m_in;
   logic [WEIGHT_W-1:0] last_w_ff, last_w_in;
   logic [ADDR_W-1:0]   last_a_ff, last_a_in;
   logic                have_last_ff, have_last_in;
   logic [CW-1:0]       rank_ff, rank_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   aht_rsp_type rsp_ff, rsp_in;

   // memory ports
   logic               tab_we;
   logic [IW-1:0]      tab_waddr;
   aht_tab_entry_type  tab_wdata, tab_rd;
   logic               work_we;
   logic [IW-1:0]      work_waddr;
   aht_work_entry_type work_wdata, work_rd;

   // merge and rank helpers
   logic [HITS_W-1:0] hit_diff;
   logic              merge_ok;
   logic [HITS_W-1:0] hits_next;
   logic              rank_last;
   logic              accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // entry table
   aht_ram #(
      .WIDTH ($bits(aht_tab_entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (scan_j_ff[IW-1:0]),
      .rd_data (tab_rd)
   );

   // coalesced entries for ranking
   aht_ram #(
      .WIDTH ($bits(aht_work_entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_waddr),
      .wr_data (work_wdata),
      .rd_addr (scan_j_ff[IW-1:0]),
      .rd_data (work_rd)
   );

   // scan sequencing: one read issued per cycle, its data valid in the cycle after
   always_comb begin
      scanning   = (state_ff == S_LSCAN) || (state_ff == S_DSCAN) ||
                   (state_ff == S_SSCAN) || (state_ff == S_RSCAN);
      scan_limit = (state_ff == S_RSCAN) ? m_ff : cnt_ff;
      scan_issue = scanning && (scan_j_ff < scan_limit);
      data_last  = scan_v_ff && ((CW'(scan_k_ff) + CW'(1)) == scan_limit);
      scan_done  = data_last || (scan_limit == '0);
      scan_j_in  = scan_issue ? (scan_j_ff + CW'(1)) : (scanning ? scan_j_ff : '0);
      scan_v_in  = scan_issue;
      scan_k_in  = scan_j_ff[IW-1:0];
   end

   // merge test and saturating hit increment
   always_comb begin
      hit_diff  = (best_hits_ff > head_hits_ff) ? (best_hits_ff - head_hits_ff)
                                                : (head_hits_ff - best_hits_ff);
      merge_ok  = (best_addr_ff == (prev_ff + {{(ADDR_W-CSR_DATA_W){1'b0}}, stride_ff})) &&
                  (hit_diff < {{(HITS_W-CSR_DATA_W){1'b0}}, window_ff});
      hits_next = (best_hits_ff == HIT_MAX) ? best_hits_ff : (best_hits_ff + HITS_W'(1));
      rank_last = ((rank_ff + CW'(1)) == m_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_payload.req_type == REQ_LOG) begin
                  state_in = S_LSCAN;
               end else if (cnt_ff == '0) begin
                  state_in = S_IDLE;
               end else if (sort_en_ff) begin
                  state_in = S_SSCAN;
               end else begin
                  state_in = S_DSCAN;
               end
            end
         end
         S_LSCAN: begin
            if (scan_done) state_in = S_LFIN;
         end
         S_LFIN: begin
            state_in = S_IDLE;
         end
         S_DSCAN: begin
            if (scan_done) state_in = S_IDLE;
         end
         S_SSCAN: begin
            if (scan_done) state_in = S_SMERGE;
         end
         S_SMERGE: begin
            state_in = found_ff ? S_SSCAN : S_RSCAN;
         end
         S_RSCAN: begin
            if (scan_done) state_in = S_REMIT;
         end
         S_REMIT: begin
            state_in = rank_last ? S_IDLE : S_RSCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, memory writes and results
   always_comb begin
      cnt_in        = cnt_ff;
      insn_in       = insn_ff;
      req_addr_in   = req_addr_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      best_addr_in  = best_addr_ff;
      best_hits_in  = best_hits_ff;
      best_run_in   = best_run_ff;
      best_w_in     = best_w_ff;
      lower_in      = lower_ff;
      have_lower_in = have_lower_ff;
      head_addr_in  = head_addr_ff;
      head_hits_in  = head_hits_ff;
      head_run_in   = head_run_ff;
      prev_in       = prev_ff;
      have_head_in  = have_head_ff;
      m_in          = m_ff;
      last_w_in     = last_w_ff;
      last_a_in     = last_a_ff;
      have_last_in  = have_last_ff;
      rank_in       = rank_ff;
      tab_we        = 1'b0;
      tab_waddr     = hit_idx_ff;
      tab_wdata     = '{addr: req_addr_ff, hits: hits_next, run: best_run_ff};
      work_we       = 1'b0;
      work_waddr    = m_ff[IW-1:0];
      work_wdata    = '{addr: head_addr_ff, hits: head_hits_ff, run: head_run_ff,
                        weight: weight_of(head_run_ff, head_hits_ff)};
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      rsp_in.instruction_total = insn_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               if (req_payload.req_type == REQ_LOG) begin
                  req_addr_in = req_payload.address;
                  if (insn_ff != INSN_MAX) insn_in = insn_ff + INSN_W'(1);
               end else if (cnt_ff == '0) begin
                  // empty table answers without a scan
                  rsp_valid_in  = 1'b1;
                  rsp_in.kind   = KIND_DUMP;
                  rsp_in.last   = 1'b1;
               end else begin
                  m_in          = '0;
                  have_head_in  = 1'b0;
                  have_lower_in = 1'b0;
               end
            end
         end
         S_LSCAN: begin
            // look for the request address
            if (scan_v_ff && !found_ff && (tab_rd.addr == req_addr_ff)) begin
               found_in     = 1'b1;
               hit_idx_in   = scan_k_ff;
               best_hits_in = tab_rd.hits;
               best_run_in  = tab_rd.run;
            end
         end
         S_LFIN: begin
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = KIND_LOG;
            rsp_in.entry_address = req_addr_ff;
            rsp_in.last          = 1'b1;
            if (found_ff) begin
               // hit: bump count and write back
               tab_we             = 1'b1;
               rsp_in.entry_index = IDX_W'(hit_idx_ff);
               rsp_in.run_length  = best_run_ff;
               rsp_in.hit_total   = hits_next;
            end else if (cnt_ff == CW'(TABLE_ENTRIES)) begin
               rsp_in.entry_index  = IDX_W'(TABLE_ENTRIES);
               rsp_in.dropped_full = 1'b1;
            end else begin
               // append new entry
               tab_we             = 1'b1;
               tab_waddr          = cnt_ff[IW-1:0];
               tab_wdata          = '{addr: req_addr_ff, hits: HITS_W'(1), run: RUN_W'(1)};
               cnt_in             = cnt_ff + CW'(1);
               rsp_in.entry_index = IDX_W'(cnt_ff);
               rsp_in.run_length  = RUN_W'(1);
               rsp_in.hit_total   = HITS_W'(1);
               rsp_in.newly_added = 1'b1;
            end
         end
         S_DSCAN: begin
            // insertion order, one result per entry
            if (scan_v_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = KIND_DUMP;
               rsp_in.entry_index   = IDX_W'(scan_k_ff);
               rsp_in.entry_address = tab_rd.addr;
               rsp_in.run_length    = tab_rd.run;
               rsp_in.hit_total     = tab_rd.hits;
               rsp_in.entry_present = 1'b1;
               rsp_in.last          = data_last;
            end
            if (scan_done) cnt_in = '0;
         end
         S_SSCAN: begin
            // smallest address above the last one taken
            if (scan_v_ff && (!have_lower_ff || (tab_rd.addr > lower_ff)) &&
                (!found_ff || (tab_rd.addr < best_addr_ff))) begin
               found_in     = 1'b1;
               best_addr_in = tab_rd.addr;
               best_hits_in = tab_rd.hits;
               best_run_in  = tab_rd.run;
            end
         end
         S_SMERGE: begin
            found_in = 1'b0;
            if (found_ff) begin
               lower_in      = best_addr_ff;
               have_lower_in = 1'b1;
               prev_in       = best_addr_ff;
               if (have_head_ff && merge_ok) begin
                  // extend the current run
                  if (head_run_ff != RUN_MAX) head_run_in = head_run_ff + RUN_W'(1);
               end else begin
                  // close the current run, open a new one
                  if (have_head_ff) begin
                     work_we = 1'b1;
                     m_in    = m_ff + CW'(1);
                  end
                  have_head_in = 1'b1;
                  head_addr_in = best_addr_ff;
                  head_hits_in = best_hits_ff;
                  head_run_in  = best_run_ff;
               end
            end else begin
               // ordering finished: flush the open run, start ranking
               work_we      = 1'b1;
               m_in         = m_ff + CW'(1);
               have_last_in = 1'b0;
               rank_in      = '0;
            end
         end
         S_RSCAN: begin
            // best entry ranking after the last one emitted
            if (scan_v_ff &&
                (!have_last_ff || ranks_before(last_w_ff, last_a_ff,
                                               work_rd.weight, work_rd.addr)) &&
                (!found_ff || ranks_before(work_rd.weight, work_rd.addr,
                                           best_w_ff, best_addr_ff))) begin
               found_in     = 1'b1;
               best_addr_in = work_rd.addr;
               best_hits_in = work_rd.hits;
               best_run_in  = work_rd.run;
               best_w_in    = work_rd.weight;
            end
         end
         S_REMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = KIND_DUMP;
            rsp_in.entry_index   = IDX_W'(rank_ff);
            rsp_in.entry_address = best_addr_ff;
            rsp_in.run_length    = best_run_ff;
            rsp_in.hit_total     = best_hits_ff;
            rsp_in.entry_present = 1'b1;
            rsp_in.last          = rank_last;
            last_w_in    = best_w_ff;
            last_a_in    = best_addr_ff;
            have_last_in = 1'b1;
            rank_in      = rank_ff + CW'(1);
            found_in     = 1'b0;
            if (rank_last) cnt_in = '0;
         end
         default: begin
            found_in = 1'b0;
         end
      endcase

      rsp_in.weighted_count = weight_of(rsp_in.run_length, rsp_in.hit_total);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         insn_ff      <= '0;
         sort_en_ff   <= SORT_ENABLE_RST;
         stride_ff    <= ADDRESS_STRIDE_RST;
         window_ff    <= HIT_WINDOW_RST;
         scan_v_ff    <= 1'b0;
         scan_j_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         insn_ff      <= insn_in;
         scan_v_ff    <= scan_v_in;
         scan_j_ff    <= scan_j_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SORT_ENABLE:    sort_en_ff <= csr_wdata[0];
               CSR_ADDRESS_STRIDE: stride_ff  <= csr_wdata;
               CSR_HIT_WINDOW:     window_ff  <= csr_wdata;
               default:            ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_k_ff     <= scan_k_in;
      req_addr_ff   <= req_addr_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      best_addr_ff  <= best_addr_in;
      best_hits_ff  <= best_hits_in;
      best_run_ff   <= best_run_in;
      best_w_ff     <= best_w_in;
      lower_ff      <= lower_in;
      have_lower_ff <= have_lower_in;
      head_addr_ff  <= head_addr_in;
      head_hits_ff  <= head_hits_in;
      head_run_ff   <= head_run_in;
      prev_ff       <= prev_in;
      have_head_ff  <= have_head_in;
      m_ff          <= m_in;
      last_w_ff     <= last_w_in;
      last_a_ff     <= last_a_in;
      have_last_ff  <= have_last_in;
      rank_ff       <= rank_in;
      rsp_ff        <= rsp_in;
   end

endmodule

[hdl/aht_checker.sv]
// ----------------------------------------------------------------------------
// aht_checker
// Port level checks for the address hit profile table.
// ----------------------------------------------------------------------------
module aht_checker
   import aht_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input aht_req_type           req_payload,
   input logic                  rsp_valid,
   input aht_rsp_type           rsp_payload,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // a log acknowledge is always the single, last result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_LOG) |->
         rsp_payload.last && !rsp_payload.entry_present)
      else $error("log acknowledge not marked last or marked present");

   // an address is never both inserted and dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.newly_added && rsp_payload.dropped_full))
      else $error("inserted and dropped at once");

   // ranking key matches its factors
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.weighted_count ==
         weight_of(rsp_payload.run_length, rsp_payload.hit_total))
      else $error("weighted count mismatch");

   // a request finishes together with its last result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_payload.last)
      else $error("busy dropped without a last result");

endmodule

bind address_hit_profile_table aht_checker u_aht_checker (.*);

[tb/tb_address_hit_profile_table.sv]
// ----------------------------------------------------------------------------
// tb_address_hit_profile_table
// Self-checking bench for the address hit profile table: requests are driven
// through the start/busy port, a behavioral table model predicts every log
// acknowledge and dump entry, and each strobed response is matched in order.
// ----------------------------------------------------------------------------
module tb_address_hit_profile_table
   import aht_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 64;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   aht_req_type req_payload;
   logic        rsp_valid;
   aht_rsp_type rsp_payload;
   logic        csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   address_hit_profile_table #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // predicted table state
   logic [ADDR_W-1:0] tab_addr [ENTRIES];
   logic [HITS_W-1:0] tab_hits [ENTRIES];
   logic [RUN_W-1:0]  tab_run  [ENTRIES];
   int                tab_count;
   logic [INSN_W-1:0] insn_seen;
   logic              cfg_sort;
   logic [7:0]        cfg_stride;
   logic [7:0]        cfg_window;

   aht_rsp_type pending_rsps [$];
   int          mismatches;
   int          requests_sent;
   bit          idle_bursts;
   bit          start_held;

   function automatic aht_rsp_type make_rsp(logic kind, logic [IDX_W-1:0] idx,
                                            logic [ADDR_W-1:0] addr,
                                            logic [RUN_W-1:0] run,
                                            logic [HITS_W-1:0] hits,
                                            logic added, logic dropped,
                                            logic present, logic fin);
      aht_rsp_type rsp;
      logic [RUN_W+HITS_W-1:0] prod;
      prod = run * hits;
      rsp.kind              = kind;
      rsp.entry_index       = idx;
      rsp.entry_address     = addr;
      rsp.run_length        = run;
      rsp.hit_total         = hits;
      rsp.weighted_count    = prod[WEIGHT_W-1:0];
      rsp.instruction_total = insn_seen;
      rsp.newly_added       = added;
      rsp.dropped_full      = dropped;
      rsp.entry_present     = present;
      rsp.last              = fin;
      return rsp;
   endfunction

   // log: count the instruction, then hit, insert or drop
   task automatic predict_log(logic [ADDR_W-1:0] addr);
      int i;
      if (insn_seen != INSN_MAX) insn_seen++;
      for (i = 0; i < tab_count; i++) begin
         if (tab_addr[i] == addr) begin
            if (tab_hits[i] != HIT_MAX) tab_hits[i]++;
            pending_rsps.push_back(make_rsp(KIND_LOG, IDX_W'(i), addr, tab_run[i],
                                            tab_hits[i], 0, 0, 0, 1));
            return;
         end
      end
      if (tab_count >= ENTRIES) begin
         pending_rsps.push_back(make_rsp(KIND_LOG, IDX_W'(ENTRIES), addr, 0, 0, 0, 1, 0, 1));
         return;
      end
      tab_addr[tab_count] = addr;
      tab_hits[tab_count] = 1;
      tab_run[tab_count]  = 1;
      pending_rsps.push_back(make_rsp(KIND_LOG, IDX_W'(tab_count), addr, 1, 1, 1, 0, 0, 1));
      tab_count++;
   endtask

   // dump: optional address sort, run coalescing and weight ranking
   task automatic predict_dump();
      logic [ADDR_W-1:0]   a [ENTRIES];
      logic [HITS_W-1:0]   h [ENTRIES];
      logic [RUN_W-1:0]    r [ENTRIES];
      bit                  keep [ENTRIES];
      logic [ADDR_W-1:0]   ka, prev;
      logic [HITS_W-1:0]   kh, diff;
      logic [RUN_W-1:0]    kr;
      logic [WEIGHT_W-1:0] kw, wj;
      int n, m, i, j, head;
      n = tab_count;
      if (n == 0) begin
         pending_rsps.push_back(make_rsp(KIND_DUMP, 0, 0, 0, 0, 0, 0, 0, 1));
         return;
      end
      for (i = 0; i < n; i++) begin
         a[i] = tab_addr[i];
         h[i] = tab_hits[i];
         r[i] = tab_run[i];
         keep[i] = 1;
      end
      if (cfg_sort) begin
         // ascending address, then run length
         for (i = 1; i < n; i++) begin
            ka = a[i]; kh = h[i]; kr = r[i];
            j = i;
            while (j > 0 && (a[j-1] > ka || (a[j-1] == ka && r[j-1] > kr))) begin
               a[j] = a[j-1]; h[j] = h[j-1]; r[j] = r[j-1];
               j--;
            end
            a[j] = ka; h[j] = kh; r[j] = kr;
         end
         // fold stride runs into their heads
         head = 0;
         prev = a[0];
         for (i = 1; i < n; i++) begin
            diff = (h[i] > h[head]) ? h[i] - h[head] : h[head] - h[i];
            if (a[i] == prev + ADDR_W'(cfg_stride) && diff < HITS_W'(cfg_window)) begin
               keep[i] = 0;
               if (r[head] != RUN_MAX) r[head]++;
            end else begin
               head = i;
            end
            prev = a[i];
         end
         m = 0;
         for (i = 0; i < n; i++) begin
            if (keep[i]) begin
               a[m] = a[i]; h[m] = h[i]; r[m] = r[i];
               m++;
            end
         end
         n = m;
         // heavier first, lower address on ties
         for (i = 1; i < n; i++) begin
            ka = a[i]; kh = h[i]; kr = r[i];
            kw = kr * kh;
            j = i;
            while (j > 0) begin
               wj = r[j-1] * h[j-1];
               if (!(kw > wj || (kw == wj && ka < a[j-1]))) break;
               a[j] = a[j-1]; h[j] = h[j-1]; r[j] = r[j-1];
               j--;
            end
            a[j] = ka; h[j] = kh; r[j] = kr;
         end
      end
      for (i = 0; i < n; i++)
         pending_rsps.push_back(make_rsp(KIND_DUMP, IDX_W'(i), a[i], r[i], h[i], 0, 0, 1,
                                         i + 1 == n));
      tab_count = 0;
   endtask

   // response checker
   always @(posedge clock) begin
      aht_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: %p", rsp_payload);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload.kind !== want.kind ||
                rsp_payload.entry_index !== want.entry_index ||
                rsp_payload.entry_address !== want.entry_address ||
                rsp_payload.run_length !== want.run_length ||
                rsp_payload.hit_total !== want.hit_total ||
                rsp_payload.weighted_count !== want.weighted_count ||
                rsp_payload.instruction_total !== want.instruction_total ||
                rsp_payload.newly_added !== want.newly_added ||
                rsp_payload.dropped_full !== want.dropped_full ||
                rsp_payload.entry_present !== want.entry_present ||
                rsp_payload.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  expected %p", want);
                  $display("  actual   %p", rsp_payload);
               end
            end
         end
      end
   end

   // drop start if the last request left it high
   task automatic release_start();
      if (start_held) begin
         start <= 1'b0;
         start_held = 0;
      end
   endtask

   task automatic send_request(logic kind, logic [ADDR_W-1:0] addr);
      aht_req_type req;
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         release_start();
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req.req_type = kind;
      req.address  = addr;
      start <= 1'b1;
      req_payload <= req;
      start_held = 1;
      do @(posedge clock); while (busy);
      if (kind == REQ_DUMP) predict_dump();
      else predict_log(addr);
      requests_sent++;
   endtask

   task automatic log_addr(logic [ADDR_W-1:0] addr);
      send_request(REQ_LOG, addr);
   endtask

   task automatic dump_table();
      send_request(REQ_DUMP, {$urandom, $urandom});
   endtask

   // wait until every response is in and the block is idle
   task automatic drain();
      release_start();
      @(posedge clock);
      while (pending_rsps.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SORT_ENABLE) cfg_sort = val[0];
      else if (idx == CSR_ADDRESS_STRIDE) cfg_stride = val;
      else if (idx == CSR_HIT_WINDOW) cfg_window = val;
   endtask

   task automatic test_empty_dump();
      dump_table();
   endtask

   // address extremes, repeat hits, dump with defaults
   task automatic test_log_extremes();
      log_addr('0);
      log_addr('1);
      log_addr('0);
      log_addr(64'hFFFF_FFFF_FFFF_FFFC);
      log_addr('1);
      log_addr('0);
      dump_table();
   endtask

   // stride runs merge, a hit gap breaks a run, addresses at both ends are logged
   task automatic test_merge_and_rank();
      log_addr(64'h1000);
      log_addr(64'h1004);
      log_addr(64'h1008);
      log_addr(64'h1008);
      log_addr(64'h100C);
      repeat (6) log_addr(64'h100C);
      log_addr(64'h2000);
      log_addr(64'h2000);
      log_addr(64'hFFFF_FFFF_FFFF_FFFC);
      log_addr(64'h0);
      dump_table();
   endtask

   // insertion order, and no merging with zero stride or window
   task automatic test_config_extremes();
      write_csr(CSR_SORT_ENABLE, 8'hFE);
      log_addr(64'h30);
      log_addr(64'h10);
      log_addr(64'h20);
      dump_table();
      write_csr(CSR_SORT_ENABLE, 8'h01);
      write_csr(CSR_ADDRESS_STRIDE, 8'h00);
      log_addr(64'h40);
      log_addr(64'h40);
      dump_table();
      write_csr(CSR_ADDRESS_STRIDE, 8'h10);
      write_csr(CSR_HIT_WINDOW, 8'h00);
      write_csr(2'd3, 8'hFF);
      log_addr(64'h40);
      log_addr(64'h50);
      dump_table();
   endtask

   // fill every entry, then overflow with new and known addresses
   task automatic test_table_full();
      logic [ADDR_W-1:0] base;
      int i;
      base = {$urandom, $urandom};
      for (i = 0; i < ENTRIES; i++) log_addr(base + i * cfg_stride);
      log_addr(~base);
      log_addr(base);
      log_addr(base ^ 64'h8000_0000_0000_0000);
      dump_table();
   endtask

   // stride clusters with random hits plus noise, then a dump in most rounds
   task automatic test_random_traffic(int target);
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] cluster [$];
      int n, i, k, phase;
      phase = 0;
      while (requests_sent < target) begin
         if (requests_sent > target - 50) idle_bursts = 0;
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: write_csr(CSR_SORT_ENABLE, CSR_DATA_W'($urandom));
               1: write_csr(CSR_ADDRESS_STRIDE, 8'd1);
               2: write_csr(CSR_ADDRESS_STRIDE, 8'd255);
               3: write_csr(CSR_ADDRESS_STRIDE, CSR_DATA_W'($urandom_range(1, 255)));
               4: write_csr(CSR_HIT_WINDOW, $urandom_range(0, 1) ? 8'd255 : 8'd1);
               default: write_csr(CSR_HIT_WINDOW, CSR_DATA_W'($urandom_range(1, 8)));
            endcase
         end
         base = {$urandom, $urandom};
         n = $urandom_range(1, 10);
         cluster.delete();
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) cluster.push_back({$urandom, $urandom});
            else cluster.push_back(base + i * cfg_stride);
         end
         k = n * $urandom_range(1, 3);
         for (i = 0; i < k; i++) log_addr(cluster[$urandom_range(0, n - 1)]);
         if (phase % 4 == 2) drain();
         if ($urandom_range(0, 5) != 0) dump_table();
         phase++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tab_count = 0;
      insn_seen = '0;
      cfg_sort = SORT_ENABLE_RST;
      cfg_stride = ADDRESS_STRIDE_RST;
      cfg_window = HIT_WINDOW_RST;
      mismatches = 0;
      requests_sent = 0;
      idle_bursts = 1;
      start_held = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_dump();
      test_log_extremes();
      test_merge_and_rank();
      test_config_extremes();
      test_table_full();
      test_random_traffic(260);
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("address_hit_profile_table test passed");
      end else begin
         $display("address_hit_profile_table test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      $display("address_hit_profile_table test failed");
      $finish;
   end

endmodule
